// ===== rtl/core/sau_pkg.sv =====
package sau_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned ENTRY_W     = 7;
  localparam int unsigned STACK_DEPTH = 64;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_NOP  = 3'd5;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SHORT    = 2'd1,
    STAT_DIVZERO  = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIVW
  } state_t;

endpackage

// ===== rtl/core/sau_ram.sv =====
module sau_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/sau_div.sv =====
module sau_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  iter_r;
  logic        neg_r;
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] dvs_r;
  logic [32:0] trial;
  logic [31:0] dividend_mag;
  logic [31:0] divisor_mag;

  assign dividend_mag = dividend[31] ? (32'd0 - dividend) : dividend;
  assign divisor_mag  = divisor[31] ? (32'd0 - divisor) : divisor;
  assign trial        = {rem_r, quo_r[31]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= 5'd0;
      end else if (busy_r) begin
        iter_r <= iter_r + 5'd1;
        if (iter_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle, restoring, on the magnitudes.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[31] ^ divisor[31];
      rem_r <= 32'd0;
      quo_r <= dividend_mag;
      dvs_r <= divisor_mag;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_r <= trial[31:0];
      end else begin
        rem_r <= {rem_r[30:0], quo_r[31]};
      end
      quo_r <= {quo_r[30:0], ~trial[32]};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - quo_r) : quo_r;

endmodule

// ===== rtl/core/stack_arithmetic_unit.sv =====
// Push, nop, unused codes, overflow and a short stack: strobe in the cycle after the transfer.
// Add, sub, mul and a zero divisor: via ST_EXEC, set by the registered read of the second entry.
// Div: via ST_EXEC and ST_DIVW, set by the 32 iterations of the bit-serial divider.
// One item at a time: busy is high while an add, sub, mul or div executes; results cannot be stalled.
// Synchronous active-low reset empties the stack; the operand memory is not cleared.
module stack_arithmetic_unit #(
  parameter int unsigned STACK_DEPTH = sau_pkg::STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_push_value,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_top_value,
  output logic [6:0]         out_entry_count
);

  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  sau_pkg::state_t  state_r, state_nxt;
  sau_pkg::status_t status_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_m2;
  logic [31:0]      top_r, top_nxt;
  logic [2:0]       cmd_r;
  logic             accept;
  logic             full;
  logic             short_stack;
  logic             is_arith;
  logic             fin;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [31:0]      wdata;
  logic [31:0]      second;
  logic [31:0]      alu;

  logic             div_start;
  logic             div_done;
  logic [31:0]      quotient;

  logic             out_strobe_r;
  logic [1:0]       out_status_r;
  logic [31:0]      out_top_r;
  logic [6:0]       out_count_r;

  assign accept      = start && (state_r == sau_pkg::ST_IDLE);
  assign full        = cnt_r >= CNT_W'(STACK_DEPTH);
  assign short_stack = cnt_r < CNT_W'(2);
  assign cnt_m2      = cnt_r - CNT_W'(2);
  assign is_arith    = (in_cmd == sau_pkg::CMD_ADD) || (in_cmd == sau_pkg::CMD_SUB) ||
                       (in_cmd == sau_pkg::CMD_MUL) || (in_cmd == sau_pkg::CMD_DIV);

  sau_ram #(
    .WIDTH (sau_pkg::DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (second)
  );

  sau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (second),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    case (cmd_r)
      sau_pkg::CMD_ADD: alu = second + top_r;
      sau_pkg::CMD_SUB: alu = second - top_r;
      default:          alu = second * top_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sau_pkg::ST_IDLE: begin
        if (accept && is_arith && !short_stack) begin
          state_nxt = sau_pkg::ST_EXEC;
        end
      end
      sau_pkg::ST_EXEC: begin
        if ((cmd_r == sau_pkg::CMD_DIV) && (top_r != 32'd0)) begin
          state_nxt = sau_pkg::ST_DIVW;
        end else begin
          state_nxt = sau_pkg::ST_IDLE;
        end
      end
      sau_pkg::ST_DIVW: begin
        if (div_done) begin
          state_nxt = sau_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sau_pkg::ST_IDLE;
    endcase
  end

  // The entry below the top is read every cycle, but its data is used only in the
  // cycle after a transfer, by which time every earlier write has landed.
  always_comb begin
    cnt_nxt    = cnt_r;
    top_nxt    = top_r;
    we         = 1'b0;
    waddr      = cnt_m2[AW-1:0];
    wdata      = alu;
    div_start  = 1'b0;
    fin        = 1'b0;
    status_nxt = sau_pkg::STAT_OK;
    unique case (state_r)
      sau_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == sau_pkg::CMD_PUSH) begin
            fin = 1'b1;
            if (full) begin
              status_nxt = sau_pkg::STAT_OVERFLOW;
            end else begin
              we      = 1'b1;
              waddr   = cnt_r[AW-1:0];
              wdata   = in_push_value;
              top_nxt = in_push_value;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end else if (is_arith) begin
            if (short_stack) begin
              fin        = 1'b1;
              status_nxt = sau_pkg::STAT_SHORT;
            end
          end else begin
            fin = 1'b1;
          end
        end
      end
      sau_pkg::ST_EXEC: begin
        if (cmd_r == sau_pkg::CMD_DIV) begin
          if (top_r == 32'd0) begin
            fin        = 1'b1;
            status_nxt = sau_pkg::STAT_DIVZERO;
          end else begin
            div_start = 1'b1;
          end
        end else begin
          fin     = 1'b1;
          we      = 1'b1;
          top_nxt = alu;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      sau_pkg::ST_DIVW: begin
        if (div_done) begin
          fin     = 1'b1;
          we      = 1'b1;
          wdata   = quotient;
          top_nxt = quotient;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sau_pkg::ST_IDLE;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (accept) begin
      cmd_r <= in_cmd;
    end
    if (fin) begin
      out_status_r <= status_nxt;
      out_top_r    <= (cnt_nxt == '0) ? 32'd0 : top_nxt;
      out_count_r  <= sau_pkg::ENTRY_W'(cnt_nxt);
    end
  end

  assign busy            = (state_r != sau_pkg::ST_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_top_value   = out_top_r;
  assign out_entry_count = out_count_r;

endmodule

// ===== rtl/core/sau_checker.sv =====
module sau_checker #(
  parameter int unsigned STACK_DEPTH = sau_pkg::STACK_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_cmd,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [31:0] out_top_value,
  input logic [6:0]  out_entry_count
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_strobe)
    else $error("block not idle after reset");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_cmd == sau_pkg::CMD_PUSH || in_cmd == sau_pkg::CMD_NOP)
    |=> out_strobe && !busy)
    else $error("push or nop did not finish in one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while still busy");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_entry_count == 7'd0 |-> out_top_value == 32'd0)
    else $error("empty stack reports a non-zero top");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == sau_pkg::STAT_OVERFLOW
    |-> out_entry_count == 7'(STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

endmodule

bind stack_arithmetic_unit sau_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_sau_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_cmd          (in_cmd),
  .out_strobe      (out_strobe),
  .out_status      (out_status),
  .out_top_value   (out_top_value),
  .out_entry_count (out_entry_count)
);
